// File: src/p1305_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// p1305_pkg
// Shared constants and helpers for the poly1305 engine.
// ----------------------------------------------------------------------------
package p1305_pkg;

  localparam int unsigned AccW = 131;
  localparam int unsigned BlkW = 136;

  localparam logic [129:0] PrimeP = {2'b11, {124{1'b1}}, 4'b1011};

  localparam logic [1:0] RegRLow  = 2'd0;
  localparam logic [1:0] RegRHigh = 2'd1;
  localparam logic [1:0] RegSLow  = 2'd2;
  localparam logic [1:0] RegSHigh = 2'd3;

  // clamp r as the key schedule requires
  function automatic logic [127:0] clamp_r(input logic [127:0] r);
    logic [127:0] c;
    c = r;
    c[31:28]   = 4'h0;
    c[63:60]   = 4'h0;
    c[95:92]   = 4'h0;
    c[127:124] = 4'h0;
    c[33:32]   = 2'b00;
    c[65:64]   = 2'b00;
    c[97:96]   = 2'b00;
    return c;
  endfunction

endpackage
`default_nettype wire

// File: src/poly1305_mac_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// poly1305_mac_engine_top
// Byte-serial poly1305 tag engine with a 16-entry block buffer memory.
// ----------------------------------------------------------------------------
// a byte that does not complete a block is stored and the engine stays idle
// a completed block holds off input through len buffer reads, one add,
//   then the 8-bit-digit multiply by r
// a tag goes valid after the fold, subtract and tag states; it holds until taken
// reset clears accumulator, byte count, key registers and output valid;
//   the buffer memory is not cleared
module poly1305_mac_engine_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // msg_byte
  input  wire logic         s_axis_tuser,   // has_byte
  input  wire logic         s_axis_tlast,   // is_last
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata,   // tag_low [63:0], tag_high [127:64]
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import p1305_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StAdd  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StFold = 3'd4;
  localparam logic [2:0] StSub  = 3'd5;
  localparam logic [2:0] StTag  = 3'd6;

  logic [63:0] r_lo_q, r_hi_q, s_lo_q, s_hi_q;
  logic [2:0]  state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [4:0]  len_q, len_d;
  logic [4:0]  rd_k_q, rd_k_d;
  logic [3:0]  rd_idx_q;
  logic        rd_vld_q, rd_vld_d;
  logic [7:0]  rd_data_q;
  logic        fin_q, fin_d;
  logic [3:0]  step_q, step_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [AccW-1:0] h_q, h_d;
  logic [AccW:0]   a_q, a_d;
  logic [BlkW-1:0] blk_q;
  logic        blk_clr;
  logic        out_vld_q;
  logic [127:0] tag_q;
  logic        tag_load;
  logic [7:0]  blk_mem [16];
  logic        in_acc, wr_en;
  logic [127:0] rc;
  logic [7:0]  digit;
  logic [140:0] prod;
  logic [AccW:0] diff;
  logic [127:0] tag_d;
  logic [4:0]  cnt_inc;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_lo_q <= '0;
      r_hi_q <= '0;
      s_lo_q <= '0;
      s_hi_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        RegRLow:  r_lo_q <= pwdata;
        RegRHigh: r_hi_q <= pwdata;
        RegSLow:  s_lo_q <= pwdata;
        RegSHigh: s_hi_q <= pwdata;
        default:  r_lo_q <= r_lo_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      RegRLow:  prdata = r_lo_q;
      RegRHigh: prdata = r_hi_q;
      RegSLow:  prdata = s_lo_q;
      RegSHigh: prdata = s_hi_q;
      default:  prdata = '0;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle) && !out_vld_q;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign wr_en   = in_acc && s_axis_tuser;
  assign cnt_inc = {1'b0, cnt_q} + 5'd1;

  // block buffer memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      blk_mem[cnt_q] <= s_axis_tdata;
    end
    rd_data_q <= blk_mem[rd_k_q[3:0]];
  end

  assign rc    = clamp_r({r_hi_q, r_lo_q});
  assign digit = rc[{step_q, 3'b000} +: 8];
  // h*256 + a*digit, then fold bits at 2^130 and up back in times 5
  assign prod  = {2'b00, h_q, 8'h00} + ({9'd0, a_q} * {133'd0, digit});
  assign diff  = {1'b0, acc_q} - {2'b00, PrimeP};
  assign tag_d = acc_q[127:0] + {s_hi_q, s_lo_q};

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    rd_k_d   = rd_k_q;
    rd_vld_d = 1'b0;
    fin_d    = fin_q;
    step_d   = step_q;
    acc_d    = acc_q;
    h_d      = h_q;
    a_d      = a_q;
    blk_clr  = 1'b0;
    tag_load = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (s_axis_tuser && cnt_inc == 5'd16) begin
            len_d   = 5'd16;
            cnt_d   = '0;
            fin_d   = s_axis_tlast;
            rd_k_d  = '0;
            blk_clr = 1'b1;
            state_d = StRead;
          end else begin
            if (s_axis_tuser) begin
              cnt_d = cnt_inc[3:0];
            end
            if (s_axis_tlast) begin
              cnt_d = '0;
              fin_d = 1'b1;
              if ((s_axis_tuser ? cnt_inc : {1'b0, cnt_q}) != 5'd0) begin
                len_d   = s_axis_tuser ? cnt_inc : {1'b0, cnt_q};
                rd_k_d  = '0;
                blk_clr = 1'b1;
                state_d = StRead;
              end else begin
                state_d = StFold;
              end
            end
          end
        end
      end
      StRead: begin
        if (rd_k_q < len_q) begin
          rd_vld_d = 1'b1;
          rd_k_d   = rd_k_q + 5'd1;
        end else begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        // pad byte sits right after the data
        a_d     = {1'b0, acc_q} + (AccW+1)'(blk_q)
                  + (AccW+1)'({{(BlkW-1){1'b0}}, 1'b1} << {len_q, 3'b000});
        h_d     = '0;
        step_d  = 4'd15;
        state_d = StMul;
      end
      StMul: begin
        h_d = {1'b0, prod[129:0]} + AccW'({prod[140:130], 2'b00} + {2'b00, prod[140:130]});
        if (step_q == 4'd0) begin
          acc_d   = {1'b0, prod[129:0]}
                    + AccW'({prod[140:130], 2'b00} + {2'b00, prod[140:130]});
          state_d = fin_q ? StFold : StIdle;
        end else begin
          step_d = step_q - 4'd1;
        end
      end
      StFold: begin
        acc_d   = {1'b0, acc_q[129:0]} + (acc_q[130] ? AccW'(5) : AccW'(0));
        state_d = StSub;
      end
      StSub: begin
        if (!diff[AccW]) begin
          acc_d = diff[AccW-1:0];
        end
        state_d = StTag;
      end
      StTag: begin
        tag_load = 1'b1;
        acc_d    = '0;
        fin_d    = 1'b0;
        state_d  = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      len_q     <= '0;
      rd_k_q    <= '0;
      rd_vld_q  <= 1'b0;
      fin_q     <= 1'b0;
      step_q    <= '0;
      acc_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      rd_k_q   <= rd_k_d;
      rd_vld_q <= rd_vld_d;
      fin_q    <= fin_d;
      step_q   <= step_d;
      acc_q    <= acc_d;
      if (tag_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q      <= h_d;
    a_q      <= a_d;
    rd_idx_q <= rd_k_q[3:0];
    if (tag_load) begin
      tag_q <= tag_d;
    end
    if (blk_clr) begin
      blk_q <= '0;
    end else if (rd_vld_q) begin
      blk_q[{rd_idx_q, 3'b000} +: 8] <= rd_data_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = tag_q;

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_axis_tready)
    else $error("input accepted while a block is in flight");

  a_tag_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTag) |=> (out_vld_q && acc_q == '0))
    else $error("tag not presented or accumulator not cleared");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> (len_q != 5'd0 && len_q <= 5'd16))
    else $error("block length out of range");

  a_mul_from_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAdd) |=> (state_q == StMul && step_q == 4'd15))
    else $error("multiply did not start at top digit");

endmodule
`default_nettype wire

// File: tb/poly1305_mac_engine_top_tb.sv
// ----------------------------------------------------------------------------
// poly1305_mac_engine_top_tb
// Streams byte-serial messages into the poly1305 engine under random gaps and
// output stalls, recomputes every tag with wide integer arithmetic mod 2^130-5
// and checks each tag word against the oldest predicted one.
// ----------------------------------------------------------------------------
module poly1305_mac_engine_top_tb;
  import p1305_pkg::*;

  class tag_board;
    logic [129:0] acc_q;
    logic [7:0]   blk_q [16];
    int           nbytes;
    logic [127:0] key_r, key_s;
    logic [127:0] tags_q [$];
    int           errors;

    function void clear();
      acc_q = '0;
      nbytes = 0;
      key_r = '0;
      key_s = '0;
      errors = 0;
    endfunction

    function void absorb(int len);
      logic [135:0] msg;
      logic [263:0] prod;
      logic [127:0] rc;
      msg = '0;
      for (int i = 0; i < len; i++) msg[8*i +: 8] = blk_q[i];
      msg[8*len +: 8] = 8'd1;
      rc = key_r;
      rc[31:28] = 4'h0; rc[63:60] = 4'h0; rc[95:92] = 4'h0; rc[127:124] = 4'h0;
      rc[33:32] = 2'b00; rc[65:64] = 2'b00; rc[97:96] = 2'b00;
      prod = ({128'd0, acc_q} + {128'd0, msg}) * {136'd0, rc};
      acc_q = 130'(prod % {134'd0, PrimeP});
    endfunction

    function void note_word(logic [7:0] b, logic has_b, logic last);
      logic [127:0] t;
      if (has_b) begin
        blk_q[nbytes] = b;
        nbytes++;
        if (nbytes == 16) begin
          absorb(16);
          nbytes = 0;
        end
      end
      if (last) begin
        if (nbytes != 0) absorb(nbytes);
        t = acc_q[127:0] + key_s;
        tags_q.push_back(t);
        acc_q = '0;
        nbytes = 0;
      end
    endfunction

    function void check_tag(logic [127:0] got);
      logic [127:0] want;
      if (tags_q.size() == 0) begin
        $display("%0t: unexpected tag %h", $time, got);
        errors++;
        return;
      end
      want = tags_q.pop_front();
      if (got[63:0] !== want[63:0]) begin
        $display("%0t: tag_low expected %h actual %h", $time, want[63:0], got[63:0]);
        errors++;
      end
      if (got[127:64] !== want[127:64]) begin
        $display("%0t: tag_high expected %h actual %h", $time, want[127:64],
                 got[127:64]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser, s_axis_tlast;
  logic [7:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [63:0] pwdata, prdata;

  tag_board board;
  int  hold_cycles;
  bit  tx_done;

  poly1305_mac_engine_top uut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == RegRLow) board.key_r[63:0] = val;
    if (idx == RegRHigh) board.key_r[127:64] = val;
    if (idx == RegSLow) board.key_s[63:0] = val;
    if (idx == RegSHigh) board.key_s[127:64] = val;
  endtask

  task automatic load_key(logic [127:0] r, logic [127:0] s);
    reg_write(RegRLow, r[63:0]);
    reg_write(RegRHigh, r[127:64]);
    reg_write(RegSLow, s[63:0]);
    reg_write(RegSHigh, s[127:64]);
  endtask

  // drive one word; valid stays high across back-to-back words
  task automatic send_word(logic [7:0] b, logic has_b, logic last, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b; s_axis_tuser <= has_b; s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_word(b, has_b, last);
  endtask

  task automatic send_msg(int len, bit gaps);
    for (int i = 0; i < len; i++)
      send_word(8'($urandom_range(0, 255)), 1'b1, (i == len - 1), gaps);
    if (len == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, gaps);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.tags_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  int rounds = 0;
  task automatic w_count_check();
    rounds++;
    if (rounds >= 6) tx_done = 1;
  endtask

  // receiver: random stall per word, plus requested long hold-offs
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_tag(m_axis_tdata);
  end

  initial begin
    int w;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      w = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    int len;
    board = new();
    board.clear();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0; s_axis_tlast = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_cycles = 0;
    tx_done = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero key: empty message and plain bytes
    send_msg(0, 0);
    send_msg(1, 0);
    drain();
    // all-ones key: clamp and carries at their extremes
    load_key('1, '1);
    send_word(8'hff, 1'b1, 1'b0, 0);
    send_word(8'h00, 1'b0, 1'b0, 0);   // idle word, nothing changes
    send_word(8'h00, 1'b1, 1'b0, 0);
    send_word(8'h00, 1'b0, 1'b1, 0);   // end without a byte
    for (int i = 0; i < 16; i++) send_word(8'hff, 1'b1, (i == 15), 0);
    send_msg(0, 0);
    drain();
    load_key(rand128(), rand128());
    send_msg(17, 0);
    send_msg(15, 0);

    // long output stall so the engine backs up into its input
    hold_cycles = 300;
    for (int m = 0; m < 6; m++) send_msg($urandom_range(0, 3), 0);
    drain();

    while (!tx_done) begin
      load_key(rand128(), rand128());
      for (int m = 0; m < 12; m++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
                                          : $urandom_range(0, 16);
        send_msg(len, 1);
        if ($urandom_range(0, 7) == 0)
          send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1);
      end
      drain();
      if (board.tags_q.size() == 0 && $time > 0) len = 0;
      w_count_check();
    end
    drain();
    if (board.errors == 0 && board.tags_q.size() == 0)
      $display("poly1305_mac_engine_top: match");
    else
      $display("poly1305_mac_engine_top: mismatch");
    $finish;
  end

  initial begin
    #8000000;
    $display("poly1305_mac_engine_top: mismatch");
    $finish;
  end

endmodule

// File: sim.f
src/p1305_pkg.sv
src/poly1305_mac_engine_top.sv
tb/poly1305_mac_engine_top_tb.sv
